/* hw/rtl/asc_pkg.sv */
// Package with the shared types, codes and the flag lookup of the access string checker.
package asc_pkg;

  localparam int CharWidth  = 8;
  localparam int LevelWidth = 8;
  localparam int FlagsWidth = 36;
  localparam int AccWidth   = 9;
  localparam int ModeWidth  = 3;
  localparam int VerdWidth  = 2;
  localparam int CfgIdxWidth = 1;

  localparam logic [CfgIdxWidth-1:0] REG_USER_LEVEL = 1'b0;
  localparam logic [CfgIdxWidth-1:0] REG_USER_FLAGS = 1'b1;

  localparam logic [ModeWidth-1:0] MODE_TERM   = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_SFIRST = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_SMORE  = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_FLAG   = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_SKIP   = 3'd4;
  localparam logic [ModeWidth-1:0] MODE_DONE   = 3'd5;

  localparam logic [VerdWidth-1:0] VERD_UNDEC = 2'd0;
  localparam logic [VerdWidth-1:0] VERD_GRANT = 2'd1;
  localparam logic [VerdWidth-1:0] VERD_DENY  = 2'd2;
  localparam logic [VerdWidth-1:0] VERD_ERR   = 2'd3;

  localparam logic [AccWidth-1:0] LEVEL_SAT = 9'd256;

  localparam logic [CharWidth-1:0] CH_NUL   = 8'h00;
  localparam logic [CharWidth-1:0] CH_BAR   = 8'h7c;
  localparam logic [CharWidth-1:0] CH_S     = 8'h73;
  localparam logic [CharWidth-1:0] CH_F     = 8'h66;
  localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
  localparam logic [CharWidth-1:0] CH_UA    = 8'h41;
  localparam logic [CharWidth-1:0] CH_UZ    = 8'h5a;
  localparam logic [CharWidth-1:0] CH_LA    = 8'h61;
  localparam logic [CharWidth-1:0] CH_LZ    = 8'h7a;
  localparam logic [CharWidth-1:0] DIGIT_FLAG_BASE = 8'd26;

  typedef struct packed {
    logic emit;
    logic granted;
    logic parse_error;
  } asc_result_t;

  // Returns whether the flag named by a letter or a digit is set.
  function automatic logic flag_hit(input logic [CharWidth-1:0] c,
                                    input logic [FlagsWidth-1:0] flags);
    logic [CharWidth-1:0] idx;
    logic known;
    idx = '0;
    known = 1'b0;
    if (c >= CH_UA && c <= CH_UZ) begin
      idx = c - CH_UA;
      known = 1'b1;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      idx = c - CH_LA;
      known = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      idx = c - CH_ZERO + DIGIT_FLAG_BASE;
      known = 1'b1;
    end
    return known && flags[idx[5:0]];
  endfunction

endpackage

/* hw/rtl/asc_parser.sv */
// Parser state and per-byte next-state logic of the access string checker.
module asc_parser import asc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [CharWidth-1:0]  char_q,
  input  logic [LevelWidth-1:0] user_level,
  input  logic [FlagsWidth-1:0] user_flags,
  output asc_result_t           result
);

  logic [ModeWidth-1:0] parse_mode, parse_mode_next;
  logic [AccWidth-1:0]  level_accum, level_accum_next;
  logic [VerdWidth-1:0] verdict_held, verdict_held_next;
  logic [ModeWidth-1:0] eff_mode;
  logic                 digit;
  logic [3:0]           dval;
  logic [11:0]          acc_grown;
  logic                 emit_now;
  logic [VerdWidth-1:0] emit_verd;

  assign digit     = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
  assign dval      = 4'(char_q - CH_ZERO);
  assign acc_grown = 12'(level_accum) * 12'd10 + 12'(dval);

  always_comb begin
    eff_mode = parse_mode;
    if (parse_mode == MODE_SMORE && !digit) begin
      eff_mode = ({1'b0, user_level} < level_accum) ? MODE_SKIP : MODE_TERM;
    end else if (parse_mode == MODE_FLAG &&
                 !(char_q != CH_NUL && flag_hit(char_q, user_flags))) begin
      eff_mode = MODE_SKIP;
    end
  end

  always_comb begin
    parse_mode_next   = eff_mode;
    level_accum_next  = level_accum;
    verdict_held_next = verdict_held;
    emit_now          = 1'b0;
    emit_verd         = VERD_UNDEC;
    case (eff_mode)
      MODE_DONE: begin
        if (char_q == CH_NUL) begin
          emit_now  = 1'b1;
          emit_verd = verdict_held;
        end
      end
      MODE_SFIRST: begin
        if (digit) begin
          level_accum_next = 9'(dval);
          parse_mode_next  = MODE_SMORE;
        end else if (char_q == CH_NUL) begin
          emit_now  = 1'b1;
          emit_verd = VERD_ERR;
        end else begin
          verdict_held_next = VERD_ERR;
          parse_mode_next   = MODE_DONE;
        end
      end
      MODE_SMORE: begin
        level_accum_next = (acc_grown > 12'(LEVEL_SAT)) ? LEVEL_SAT : acc_grown[AccWidth-1:0];
      end
      MODE_FLAG: begin
        parse_mode_next = MODE_TERM;
      end
      MODE_SKIP: begin
        if (char_q == CH_NUL) begin
          emit_now  = 1'b1;
          emit_verd = VERD_DENY;
        end else if (char_q == CH_BAR) begin
          parse_mode_next = MODE_TERM;
        end
      end
      default: begin
        if (char_q == CH_NUL) begin
          emit_now  = 1'b1;
          emit_verd = VERD_GRANT;
        end else if (char_q == CH_S) begin
          level_accum_next = '0;
          parse_mode_next  = MODE_SFIRST;
        end else if (char_q == CH_F) begin
          parse_mode_next = MODE_FLAG;
        end else if (char_q == CH_BAR) begin
          verdict_held_next = VERD_GRANT;
          parse_mode_next   = MODE_DONE;
        end else begin
          verdict_held_next = VERD_ERR;
          parse_mode_next   = MODE_DONE;
        end
      end
    endcase
    if (emit_now) begin
      parse_mode_next   = MODE_TERM;
      level_accum_next  = '0;
      verdict_held_next = VERD_UNDEC;
    end
  end

  assign result.emit        = emit_now;
  assign result.granted     = (emit_verd == VERD_GRANT);
  assign result.parse_error = (emit_verd == VERD_ERR);

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode   <= MODE_TERM;
      level_accum  <= '0;
      verdict_held <= VERD_UNDEC;
    end else if (advance) begin
      parse_mode   <= parse_mode_next;
      level_accum  <= level_accum_next;
      verdict_held <= verdict_held_next;
    end
  end

endmodule

/* hw/rtl/access_string_checker.sv */
// Top level of the access string checker: configuration, input and result registers.
// A string's zero byte goes through the input register, then its result is registered.
// Throughput: one byte per cycle; the input register and the parser state advance together.
// A byte is held back only while its result waits on a result register that is still full.
// Reset clears the parser state, both valid flags, user_level and user_flags at once.
module access_string_checker import asc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [FlagsWidth-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CharWidth-1:0]   char_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   granted,
  output logic                   parse_error
);

  logic [LevelWidth-1:0] user_level;
  logic [FlagsWidth-1:0] user_flags;
  logic                  s1_valid;
  logic [CharWidth-1:0]  s1_char;
  logic                  s1_adv;
  logic                  out_free;
  asc_result_t           step_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_level <= '0;
      user_flags <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_USER_LEVEL) begin
        user_level <= cfg_data[LevelWidth-1:0];
      end else if (cfg_index == REG_USER_FLAGS) begin
        user_flags <= cfg_data;
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!step_res.emit || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= char_in;
    end
  end

  asc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .char_q     (s1_char),
    .user_level (user_level),
    .user_flags (user_flags),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && step_res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step_res.emit) begin
      granted     <= step_res.granted;
      parse_error <= step_res.parse_error;
    end
  end

endmodule
